@@ hw/rtl/mmr_pkg.sv @@
`default_nettype none

package mmr_pkg;

  localparam int MAX_LEN = 64;
  localparam int DATA_W  = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int PROD_W  = 2 * DATA_W;
  localparam int STEP_W  = $clog2(DATA_W);
  localparam int ADDR_W  = 1;

  localparam logic [ADDR_W-1:0] REG_OUT_LOW  = 1'd0;
  localparam logic [ADDR_W-1:0] REG_OUT_HIGH = 1'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_EMIT
  } mmr_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic mul_en;
    logic div_start;
    logic out_load;
    logic idx_inc;
    logic clear;
  } mmr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic idx_last;
    logic out_free;
  } mmr_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/min_max_rescale.sv @@
// Min-max rescaling of a vector of signed Q8.8 samples.
// The input stream carries one sample per transaction in in_tdata, with
// in_tlast on the final element of a vector. Up to 64 samples are buffered;
// further samples of the same vector are dropped, but their tlast still ends
// the vector. While loading, one transaction is taken every cycle.
// After the last input the block emits each buffered sample, in input order,
// mapped linearly so that the vector minimum becomes out_low and the maximum
// becomes out_high (the bounds are exchanged if out_low exceeds out_high).
// A flat vector gives the midpoint of the bounds for every element.
// Each result passes through a memory read, a 16x16 multiply, and a
// restoring divider that retires one quotient bit per cycle; out_tlast
// marks the final result. No input is accepted while a vector is being
// emitted.
// A stalled receiver holds the result register and stops the emission; the
// next vector may start loading while the final result still waits.
// Reset (rst_n low, synchronous) empties the buffer and sets out_low to 0.0
// and out_high to 1.0. The user must see that the bounds are written through
// cfg_we/cfg_addr/cfg_wdata while the block is idle; the block has no check.
`default_nettype none

module min_max_rescale (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic        [mmr_pkg::DATA_W-1:0] in_tdata,   // [15:0] sample
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic             [mmr_pkg::DATA_W-1:0] out_tdata,  // [15:0] scaled
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic        [mmr_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic        [mmr_pkg::DATA_W-1:0] cfg_wdata
);

  mmr_pkg::mmr_cmd_t cmd;
  mmr_pkg::mmr_sts_t sts;

  mmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mmr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  ($signed(in_tdata)),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mmr_div.sv @@
`default_nettype none

module mmr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mmr_pkg::PROD_W-1:0]    dividend,
  input  wire logic [mmr_pkg::DATA_W-1:0]    divisor,
  output logic                               done,
  output logic      [mmr_pkg::DATA_W-1:0]    quotient
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // that the quotient fits in DATA_W bits, so the upper half of the
  // dividend starts out as a remainder below the divisor.
  logic [mmr_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [mmr_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [mmr_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [mmr_pkg::DATA_W:0]   shifted;
  logic [mmr_pkg::DATA_W:0]   trial;

  always_comb begin
    shifted  = {rem_r, quo_r[mmr_pkg::DATA_W-1]};
    trial    = shifted - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[mmr_pkg::PROD_W-1:mmr_pkg::DATA_W];
      quo_nxt  = dividend[mmr_pkg::DATA_W-1:0];
      step_nxt = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[mmr_pkg::DATA_W]) begin
        rem_nxt = trial[mmr_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[mmr_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[mmr_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[mmr_pkg::DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hw/rtl/mmr_dpath.sv @@
`default_nettype none

module mmr_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mmr_pkg::mmr_cmd_t                 cmd,
  output mmr_pkg::mmr_sts_t                      sts,
  input  wire logic signed [mmr_pkg::DATA_W-1:0] in_sample,
  input  wire logic                              cfg_we,
  input  wire logic        [mmr_pkg::ADDR_W-1:0] cfg_addr,
  input  wire logic        [mmr_pkg::DATA_W-1:0] cfg_wdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic             [mmr_pkg::DATA_W-1:0] out_tdata,
  output logic                                   out_tlast
);

  localparam logic signed [mmr_pkg::DATA_W-1:0] MIN_INIT = {1'b0, {(mmr_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [mmr_pkg::DATA_W-1:0] MAX_INIT = {1'b1, {(mmr_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [mmr_pkg::DATA_W-1:0] LOW_INIT = '0;
  localparam logic signed [mmr_pkg::DATA_W-1:0] HIGH_INIT = mmr_pkg::DATA_W'(256);

  logic        [mmr_pkg::DATA_W-1:0] mem [mmr_pkg::MAX_LEN];
  logic signed [mmr_pkg::DATA_W-1:0] rd_q_r;
  logic        [mmr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic        [mmr_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [mmr_pkg::DATA_W-1:0] min_r, min_nxt;
  logic signed [mmr_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [mmr_pkg::DATA_W-1:0] low_r, high_r;
  logic        [mmr_pkg::PROD_W-1:0] prod_r;
  logic        [mmr_pkg::DATA_W-1:0] res_data_r;
  logic                              res_last_r;
  logic                              res_valid_r, res_valid_nxt;

  logic                              store_ok;
  logic                              swap;
  logic signed [mmr_pkg::DATA_W-1:0] lo, hi;
  logic        [mmr_pkg::DATA_W:0]   span_w, diff_w, half_w, sub_w;
  logic        [mmr_pkg::DATA_W-1:0] span, diff, den, quo, result;
  logic                              flat;
  logic                              div_done;

  assign store_ok = cnt_r < mmr_pkg::CNT_W'(mmr_pkg::MAX_LEN);

  always_comb begin
    cnt_nxt = cnt_r;
    min_nxt = min_r;
    max_nxt = max_r;
    idx_nxt = idx_r;
    if (cmd.load && store_ok) begin
      cnt_nxt = cnt_r + 1'b1;
      if (in_sample < min_r) min_nxt = in_sample;
      if (in_sample > max_r) max_nxt = in_sample;
    end
    if (cmd.idx_inc) idx_nxt = idx_r + 1'b1;
    if (cmd.clear) begin
      cnt_nxt = '0;
      min_nxt = MIN_INIT;
      max_nxt = MAX_INIT;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      min_r  <= MIN_INIT;
      max_r  <= MAX_INIT;
      idx_r  <= '0;
      low_r  <= LOW_INIT;
      high_r <= HIGH_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
      idx_r <= idx_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          mmr_pkg::REG_OUT_LOW:  low_r  <= cfg_wdata;
          mmr_pkg::REG_OUT_HIGH: high_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) mem[cnt_r[mmr_pkg::IDX_W-1:0]] <= in_sample;
    if (cmd.rd_en) rd_q_r <= mem[idx_r];
  end

  always_comb begin
    swap   = low_r > high_r;
    lo     = swap ? high_r : low_r;
    hi     = swap ? low_r : high_r;
    span_w = {hi[mmr_pkg::DATA_W-1], hi} - {lo[mmr_pkg::DATA_W-1], lo};
    span   = span_w[mmr_pkg::DATA_W-1:0];
    diff_w = {max_r[mmr_pkg::DATA_W-1], max_r} - {rd_q_r[mmr_pkg::DATA_W-1], rd_q_r};
    diff   = diff_w[mmr_pkg::DATA_W-1:0];
    flat   = min_r == max_r;
    sub_w  = {max_r[mmr_pkg::DATA_W-1], max_r} - {min_r[mmr_pkg::DATA_W-1], min_r};
    den    = sub_w[mmr_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= span * diff;
  end

  mmr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  logic [mmr_pkg::DATA_W:0] hq_w;

  always_comb begin
    half_w = {lo[mmr_pkg::DATA_W-1], lo} + {hi[mmr_pkg::DATA_W-1], hi};
    hq_w   = {hi[mmr_pkg::DATA_W-1], hi} - {1'b0, quo};
    result = flat ? half_w[mmr_pkg::DATA_W:1] : hq_w[mmr_pkg::DATA_W-1:0];
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_valid_r && out_tready) res_valid_nxt = 1'b0;
    if (cmd.out_load) res_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
    if (cmd.out_load) begin
      res_data_r <= result;
      res_last_r <= sts.idx_last;
    end
  end

  assign sts.div_done = div_done;
  assign sts.idx_last = {1'b0, idx_r} == (cnt_r - 1'b1);
  assign sts.out_free = !res_valid_r || out_tready;

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_data_r;
  assign out_tlast  = res_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mmr_pkg::CNT_W'(mmr_pkg::MAX_LEN))
    else $error("sample count above capacity");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> min_r <= max_r)
    else $error("running minimum above running maximum");

  a_quo_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !flat |-> quo <= span)
    else $error("quotient exceeds the target span");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

@@ hw/rtl/mmr_ctrl.sv @@
`default_nettype none

module mmr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tlast,
  output logic                   in_tready,
  input  wire mmr_pkg::mmr_sts_t sts,
  output mmr_pkg::mmr_cmd_t      cmd
);

  mmr_pkg::mmr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmr_pkg::ST_LOAD:  if (in_tvalid && in_tlast) state_nxt = mmr_pkg::ST_READ;
      mmr_pkg::ST_READ:  state_nxt = mmr_pkg::ST_MUL;
      mmr_pkg::ST_MUL:   state_nxt = mmr_pkg::ST_START;
      mmr_pkg::ST_START: state_nxt = mmr_pkg::ST_DIV;
      mmr_pkg::ST_DIV:   if (sts.div_done) state_nxt = mmr_pkg::ST_EMIT;
      mmr_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? mmr_pkg::ST_LOAD : mmr_pkg::ST_READ;
        end
      end
      default: state_nxt = mmr_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mmr_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      mmr_pkg::ST_READ:  cmd.rd_en     = 1'b1;
      mmr_pkg::ST_MUL:   cmd.mul_en    = 1'b1;
      mmr_pkg::ST_START: cmd.div_start = 1'b1;
      mmr_pkg::ST_DIV: ;
      mmr_pkg::ST_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.idx_inc  = sts.out_free && !sts.idx_last;
        cmd.clear    = sts.out_free && sts.idx_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmr_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_min_max_rescale.sv @@
module tb_min_max_rescale;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [mmr_pkg::DATA_W-1:0] scaled;
    logic                       last;
  } rescaled_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [mmr_pkg::DATA_W-1:0] in_tdata = '0;
  logic                       in_tlast = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [mmr_pkg::DATA_W-1:0] out_tdata;
  logic                       out_tlast;
  logic                       cfg_we = 1'b0;
  logic [mmr_pkg::ADDR_W-1:0] cfg_addr = mmr_pkg::REG_OUT_LOW;
  logic [mmr_pkg::DATA_W-1:0] cfg_wdata = '0;

  // Copy of the block state used to work out the expected results.
  logic signed [mmr_pkg::DATA_W-1:0] vec_store [mmr_pkg::MAX_LEN];
  int                                vec_count = 0;
  int                                vec_min = 32767;
  int                                vec_max = -32768;
  logic signed [mmr_pkg::DATA_W-1:0] bound_low = 16'sd0;
  logic signed [mmr_pkg::DATA_W-1:0] bound_high = 16'sd256;

  rescaled_t rescaled_q [$];
  rescaled_t head_result;
  int        result_count = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  min_max_rescale dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] sample
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [15:0] scaled
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results pending",
               cycle_count, rescaled_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("ERROR: %s", msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rescaled_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected: scaled=%0d last=%0b",
                                  result_count, $signed(out_tdata), out_tlast));
      end else begin
        head_result = rescaled_q.pop_front();
        if (out_tdata !== head_result.scaled) begin
          report_mismatch($sformatf("result %0d: scaled=%0d, expected %0d", result_count,
                                    $signed(out_tdata), $signed(head_result.scaled)));
        end
        if (out_tlast !== head_result.last) begin
          report_mismatch($sformatf("result %0d: last=%0b, expected %0b", result_count,
                                    out_tlast, head_result.last));
        end
      end
      result_count++;
    end
  end

  // Buffers one sample and, on the last one, queues the rescaled vector.
  function automatic void absorb_sample(input logic signed [mmr_pkg::DATA_W-1:0] x,
                                        input logic last);
    int        lo;
    int        hi;
    int        tmp;
    longint    num;
    longint    den;
    rescaled_t r;
    if (vec_count < mmr_pkg::MAX_LEN) begin
      vec_store[vec_count] = x;
      vec_count++;
      if (int'(x) < vec_min) vec_min = int'(x);
      if (int'(x) > vec_max) vec_max = int'(x);
    end
    if (last) begin
      lo = int'(bound_low);
      hi = int'(bound_high);
      if (lo > hi) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      for (int i = 0; i < vec_count; i++) begin
        if (vec_max == vec_min) begin
          r.scaled = mmr_pkg::DATA_W'((lo + hi) >>> 1);
        end else begin
          num = longint'(hi - lo) * longint'(vec_max - int'(vec_store[i]));
          den = longint'(vec_max - vec_min);
          r.scaled = mmr_pkg::DATA_W'(longint'(hi) - num / den);
        end
        r.last = (i == vec_count - 1);
        rescaled_q.push_back(r);
      end
      vec_count = 0;
      vec_min = 32767;
      vec_max = -32768;
    end
  endfunction

  task automatic send_sample(input logic signed [mmr_pkg::DATA_W-1:0] x, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_sample(x, last);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (rescaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bounds(input logic signed [mmr_pkg::DATA_W-1:0] lo,
                            input logic signed [mmr_pkg::DATA_W-1:0] hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= mmr_pkg::REG_OUT_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    bound_low = lo;
    cfg_addr  <= mmr_pkg::REG_OUT_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    bound_high = hi;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_bounds();
    logic signed [mmr_pkg::DATA_W-1:0] a;
    logic signed [mmr_pkg::DATA_W-1:0] b;
    a = mmr_pkg::DATA_W'($urandom);
    b = mmr_pkg::DATA_W'($urandom);
    case ($urandom_range(4))
      0: set_bounds(a, b);
      1: set_bounds(-16'sd32768, 16'sd32767);
      2: set_bounds(16'sd32767, -16'sd32768);
      3: set_bounds(a, a);
      default: set_bounds(-16'sd512, 16'sd512);
    endcase
  endtask

  task automatic test_reset_bounds();
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd128, 1'b1);
  endtask

  task automatic test_extreme_bounds();
    set_bounds(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
  endtask

  task automatic test_swapped_bounds();
    set_bounds(16'sd1000, -16'sd1000);
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd300, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_equal_bounds();
    set_bounds(16'sd77, 16'sd77);
    send_sample(16'sd10, 1'b0);
    send_sample(-16'sd10, 1'b1);
  endtask

  task automatic test_flat_vector();
    set_bounds(-16'sd3, 16'sd0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd5, 1'b1);
    send_sample(-16'sd7, 1'b1);
    set_bounds(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 1'b1);
  endtask

  // The two samples past capacity carry the extremes, so they must not move
  // the minimum or maximum, while the final one still ends the vector.
  task automatic test_capacity_overflow();
    logic signed [mmr_pkg::DATA_W-1:0] x;
    set_bounds(-16'sd256, 16'sd256);
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    for (int i = 0; i < mmr_pkg::MAX_LEN; i++) begin
      x = mmr_pkg::DATA_W'($urandom_range(2000));
      x = x - 16'sd1000;
      send_sample(x, 1'b0);
    end
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
  endtask

  task automatic test_random_vectors(input int idle_send, input int stall_recv,
                                     input int n_items);
    int                                sent;
    int                                len;
    int                                mode;
    int                                span;
    logic signed [mmr_pkg::DATA_W-1:0] base;
    logic signed [mmr_pkg::DATA_W-1:0] x;
    send_idle_pct  = idle_send;
    recv_stall_pct = stall_recv;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) pick_bounds();
      len  = ($urandom_range(39) == 0) ? int'($urandom_range(60, 68))
                                       : int'($urandom_range(1, 8));
      mode = int'($urandom_range(3));
      base = mmr_pkg::DATA_W'($urandom);
      span = 1 << $urandom_range(12);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: x = mmr_pkg::DATA_W'($urandom);
          1: x = base + mmr_pkg::DATA_W'($urandom_range(span));
          2: x = base;
          default: begin
            case ($urandom_range(4))
              0: x = -16'sd32768;
              1: x = 16'sd32767;
              2: x = 16'sd0;
              3: x = -16'sd1;
              default: x = 16'sd1;
            endcase
          end
        endcase
        send_sample(x, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_bounds();
    test_extreme_bounds();
    test_swapped_bounds();
    test_equal_bounds();
    test_flat_vector();
    test_capacity_overflow();
    test_random_vectors(0, 0, 32);
    test_random_vectors(83, 0, 32);
    test_random_vectors(0, 83, 32);
    test_random_vectors(35, 35, 32);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
